// ----- hw/rtl/loop_dac_spi_register_frontend_unit_macros.svh -----
// Assertion macros used by the checker file of the loop DAC SPI frontend.
`ifndef LOOP_DAC_SPI_REGISTER_FRONTEND_UNIT_MACROS_SVH
`define LOOP_DAC_SPI_REGISTER_FRONTEND_UNIT_MACROS_SVH

// Concurrent assertion, skipped while reset is asserted.
`define LDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define LDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lds_pkg.sv -----
// Package: item types, register addresses and constants of the loop DAC SPI frontend.
`timescale 1ns / 1ps

package lds_pkg;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [6:0] ADDR_XFER       = 7'h01;
    localparam logic [6:0] ADDR_NOP        = 7'h02;
    localparam logic [6:0] ADDR_WR_MODE    = 7'h03;
    localparam logic [6:0] ADDR_DACCODE    = 7'h04;
    localparam logic [6:0] ADDR_ERR_CONFIG = 7'h05;
    localparam logic [6:0] ADDR_ERR_LOW    = 7'h06;
    localparam logic [6:0] ADDR_ERR_HIGH   = 7'h07;
    localparam logic [6:0] ADDR_RESET      = 7'h08;
    localparam logic [6:0] ADDR_STATUS     = 7'h09;

    localparam logic [15:0] RESET_WORD       = 16'hC33C;
    localparam logic [7:0]  ERR_HIGH_DEFAULT = 8'h80;

    localparam int TIMEOUT_STEP = 50;
    localparam int TIMEOUT_BASE = 40;
    localparam logic [8:0] IDLE_MAX = 9'd511;

    typedef struct packed {
        logic        kind;
        logic [7:0]  cmd_byte;
        logic [15:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  resp_command;
        logic [15:0] resp_data;
        logic        loop_alarm;
    } t_out_item;

    typedef struct packed {
        logic frame;
        logic tick;
    } t_wdog_ctl;

endpackage

// ----- hw/rtl/lds_regs.sv -----
// Register file, protected-write holding and response capture.
`timescale 1ns / 1ps

module lds_regs import lds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_frame,
    input  logic [7:0]  i_cmd_byte,
    input  logic [15:0] i_data_word,
    input  logic        i_flag,
    output logic [15:0] o_error_config,
    output logic [23:0] o_resp_hold
);

    typedef struct packed {
        logic [15:0] dac_code;
        logic [15:0] error_config;
        logic [7:0]  error_low_level;
        logic [7:0]  error_high_level;
        logic        protected_mode;
    } t_regs;

    function automatic t_regs apply_write(t_regs r, logic [6:0] addr, logic [15:0] val);
        t_regs w;
        w = r;
        unique case (addr)
            ADDR_WR_MODE:    w.protected_mode   = val[0];
            ADDR_DACCODE:    w.dac_code         = val;
            ADDR_ERR_CONFIG: w.error_config     = val;
            ADDR_ERR_LOW:    w.error_low_level  = val[15:8];
            ADDR_ERR_HIGH:   w.error_high_level = val[15:8];
            default:         w = r;
        endcase
        return w;
    endfunction

    function automatic logic is_holdable(logic [6:0] addr);
        return (addr == ADDR_WR_MODE) || (addr == ADDR_DACCODE) ||
               (addr == ADDR_ERR_CONFIG) || (addr == ADDR_ERR_LOW) ||
               (addr == ADDR_ERR_HIGH);
    endfunction

    t_regs       r_regs, n_regs;
    logic [6:0]  r_pend_addr, n_pend_addr;
    logic [15:0] r_pend_value, n_pend_value;
    logic        r_pend_valid, n_pend_valid;
    logic [23:0] r_resp_hold, n_resp_hold;

    t_regs       defaults;
    logic [6:0]  addr;
    logic [15:0] rd_value;

    assign defaults = '{dac_code: 16'h0000, error_config: 16'h0000,
                        error_low_level: 8'h00, error_high_level: ERR_HIGH_DEFAULT,
                        protected_mode: 1'b0};
    assign addr = i_cmd_byte[6:0];

    always_comb begin
        unique case (addr)
            ADDR_WR_MODE:    rd_value = {15'd0, r_regs.protected_mode};
            ADDR_DACCODE:    rd_value = r_regs.dac_code;
            ADDR_ERR_CONFIG: rd_value = r_regs.error_config;
            ADDR_ERR_LOW:    rd_value = {r_regs.error_low_level, 8'h00};
            ADDR_ERR_HIGH:   rd_value = {r_regs.error_high_level, 8'h00};
            ADDR_STATUS:     rd_value = {15'd0, i_flag};
            default:         rd_value = 16'h0000;
        endcase
    end

    always_comb begin
        n_regs       = r_regs;
        n_pend_addr  = r_pend_addr;
        n_pend_value = r_pend_value;
        n_pend_valid = r_pend_valid;
        n_resp_hold  = r_resp_hold;
        if (i_frame) begin
            if (i_cmd_byte[7]) begin
                n_resp_hold = {i_cmd_byte, rd_value};
            end else begin
                n_resp_hold = {i_cmd_byte, i_data_word};
                if (addr == ADDR_XFER) begin
                    if (r_pend_valid) begin
                        n_regs       = apply_write(r_regs, r_pend_addr, r_pend_value);
                        n_pend_valid = 1'b0;
                    end
                end else if (addr == ADDR_RESET) begin
                    if (i_data_word == RESET_WORD) begin
                        n_regs       = defaults;
                        n_pend_addr  = 7'd0;
                        n_pend_value = 16'd0;
                        n_pend_valid = 1'b0;
                    end
                end else if (is_holdable(addr)) begin
                    if (r_regs.protected_mode) begin
                        n_pend_addr  = addr;
                        n_pend_value = i_data_word;
                        n_pend_valid = 1'b1;
                    end else begin
                        n_regs = apply_write(r_regs, addr, i_data_word);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs       <= defaults;
            r_pend_addr  <= 7'd0;
            r_pend_value <= 16'd0;
            r_pend_valid <= 1'b0;
            r_resp_hold  <= 24'd0;
        end else begin
            r_regs       <= n_regs;
            r_pend_addr  <= n_pend_addr;
            r_pend_value <= n_pend_value;
            r_pend_valid <= n_pend_valid;
            r_resp_hold  <= n_resp_hold;
        end
    end

    assign o_error_config = r_regs.error_config;
    assign o_resp_hold    = r_resp_hold;

endmodule

// ----- hw/rtl/lds_wdog.sv -----
// SPI watchdog: idle millisecond counter and timeout flag.
`timescale 1ns / 1ps

module lds_wdog import lds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wdog_ctl  i_ctl,
    input  logic [3:0] i_error_config,
    output logic       o_flag
);

    logic [8:0] r_count, n_count;
    logic       r_flag, n_flag;
    logic [8:0] count_inc;
    logic [8:0] threshold;

    assign count_inc = (r_count < IDLE_MAX) ? r_count + 9'd1 : r_count;
    assign threshold = 9'(i_error_config[3:1]) * 9'(TIMEOUT_STEP) + 9'(TIMEOUT_BASE);

    always_comb begin
        n_count = r_count;
        n_flag  = r_flag;
        if (i_ctl.frame) begin
            n_count = 9'd0;
            n_flag  = 1'b0;
        end else if (i_ctl.tick) begin
            n_count = count_inc;
            if (!i_error_config[0] && (count_inc >= threshold)) begin
                n_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd0;
            r_flag  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

// ----- hw/rtl/loop_dac_spi_register_frontend_unit.sv -----
// Top level of the loop DAC SPI register frontend: input register, core and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one item per
//   handshake: a deserialized SPI frame (kind 0) or a millisecond tick (kind 1).
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one result
//   per frame: the response captured on the previous frame plus the watchdog
//   alarm as it stood before this frame. Ticks give no result.
//   An accepted frame is held in the input register and loads the result
//   register when it advances, which it does once the output side is free.
//   Throughput: one item per cycle while no frame waits on a stalled result;
//   the input register and the result register overlap items.
//   Reset (i_rst_n low, synchronous): empties both registers, restores the
//   register defaults (error high level 0x80, all else zero), clears the
//   pending protected write, the held response and the watchdog.
//   Stall: while a result waits, one more item is held in the input register;
//   ticks keep flowing past a stalled result, frames wait and o_in_ready drops.
`timescale 1ns / 1ps

module loop_dac_spi_register_frontend_unit import lds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic        advance;
    logic        in_accept;
    t_wdog_ctl   wdog_ctl;
    logic        flag;
    logic [15:0] error_config;
    logic [23:0] resp_hold;

    // Advance the held item: ticks always, frames only when the result slot frees up.
    assign advance   = r_in_valid &&
                       ((r_in_item.kind == KIND_TICK) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    assign wdog_ctl.frame = advance && (r_in_item.kind == KIND_FRAME);
    assign wdog_ctl.tick  = advance && (r_in_item.kind == KIND_TICK);

    lds_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (wdog_ctl.frame),
        .i_cmd_byte     (r_in_item.cmd_byte),
        .i_data_word    (r_in_item.data_word),
        .i_flag         (flag),
        .o_error_config (error_config),
        .o_resp_hold    (resp_hold)
    );

    lds_wdog u_wdog (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (wdog_ctl),
        .i_error_config (error_config[3:0]),
        .o_flag         (flag)
    );

    // Input register: load on accept, drop once advanced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register: capture the held response before the core overwrites it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wdog_ctl.frame) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wdog_ctl.frame) begin
            r_out_item.resp_command <= resp_hold[23:16];
            r_out_item.resp_data    <= resp_hold[15:0];
            r_out_item.loop_alarm   <= flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hw/rtl/lds_checker.sv -----
// Port-level checker of the loop DAC SPI frontend and its bind.
`timescale 1ns / 1ps
`include "loop_dac_spi_register_frontend_unit_macros.svh"

module lds_checker import lds_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `LDS_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `LDS_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "stalled result changed")
    `LDS_ASSERT(a_ready_drop, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready, "input blocked without output stall")
    `LDS_ASSERT(a_result_origin, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && (i_in_item.kind == KIND_FRAME), 2), "result without a frame two cycles earlier")

endmodule

bind loop_dac_spi_register_frontend_unit lds_checker u_lds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
